// ===== hdl/segint_pkg.sv =====
// Shared types and constants for the segment intersection block.
package segint_pkg;

  localparam int PT_BITS    = 24;
  localparam int MASK_BITS  = 6;
  localparam int SLOTS      = 4;
  localparam int FIFO_DEPTH = 4;

  typedef logic signed [PT_BITS-1:0] pt_t;

  typedef struct packed {
    logic                             is_cross;
    logic [MASK_BITS-1:0]             mask;
    logic [SLOTS-1:0][PT_BITS-1:0]    px;
    logic [SLOTS-1:0][PT_BITS-1:0]    py;
  } job_t;

  function automatic logic [1:0] slot_of(input logic [2:0] idx);
    logic [1:0] s;
    case (idx)
      3'd0: s = 2'd0;
      3'd1: s = 2'd1;
      3'd2: s = 2'd0;
      3'd3: s = 2'd1;
      3'd4: s = 2'd2;
      3'd5: s = 2'd3;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/segint_if.sv =====
// Segment pair and intersection result channel interfaces.
interface segint_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segint_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 has_point;
  logic signed [segint_pkg::PT_BITS-1:0] point_x;
  logic signed [segint_pkg::PT_BITS-1:0] point_y;
  logic                                 last_point;

  modport source (output valid, has_point, point_x, point_y, last_point, input ready);
  modport sink (input valid, has_point, point_x, point_y, last_point, output ready);
endinterface

// ===== hdl/segint_front.sv =====
// Front: classify segment pairs and compute crossing points through a pipelined divider.
module segint_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  segint_in_if.sink          in_ch,
  input  logic               q_ready,
  output logic               q_push,
  output segint_pkg::job_t   q_data
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = C + 1;
  localparam int CPW  = 2 * C + 4;
  localparam int DENW = 2 * C + 3;
  localparam int MW   = C + 1;
  localparam int PRW  = DENW + MW;
  localparam int QB   = C + F + 1;
  localparam int RW   = C + F + 3;

  typedef struct packed {
    logic signed [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_t;

  typedef struct packed {
    segint_pkg::job_t    job;
    logic [DENW-1:0]     den;
    logic [PRW-1:0]      prx, pry;
    logic [DENW-1:0]     rx, ry;
    logic [QB-1:0]       qx, qy;
    logic                nx, ny;
    logic signed [C-1:0] bx, by;
  } dv_t;

  function automatic logic signed [DW-1:0] dif(input logic signed [C-1:0] a,
                                               input logic signed [C-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [CPW-1:0] crs(input logic signed [DW-1:0] ax,
                                                input logic signed [DW-1:0] ay,
                                                input logic signed [DW-1:0] bx,
                                                input logic signed [DW-1:0] by);
    logic signed [2*DW-1:0] p, q;
    p = ax * by;
    q = bx * ay;
    return CPW'(p) - CPW'(q);
  endfunction

  function automatic logic inside_open(input logic signed [C-1:0] px,
                                       input logic signed [C-1:0] py,
                                       input logic signed [C-1:0] x0,
                                       input logic signed [C-1:0] y0,
                                       input logic signed [C-1:0] x1,
                                       input logic signed [C-1:0] y1);
    logic r;
    if (x0 != x1) begin
      r = (x0 < x1) ? (px > x0 && px < x1) : (px > x1 && px < x0);
    end else if (y0 != y1) begin
      r = (y0 < y1) ? (py > y0 && py < y1) : (py > y1 && py < y0);
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

  function automatic segint_pkg::pt_t to_pt(input logic signed [C-1:0] c);
    return segint_pkg::pt_t'(c) <<< F;
  endfunction

  function automatic segint_pkg::pt_t fix(input logic signed [C-1:0] base,
                                          input logic [QB-1:0] q,
                                          input logic rnz, input logic neg);
    logic signed [RW-1:0] res, qs;
    qs  = signed'({2'b00, q});
    res = RW'(base) <<< F;
    if (neg) begin
      res = res - qs;
      if (rnz) res = res - 1;
    end else begin
      res = res + qs;
    end
    if (res < 0 && rnz) res = res + 1;
    return segint_pkg::pt_t'(res);
  endfunction

  logic en;
  logic s1_valid, s2_valid;
  seg_t s1, s2;
  logic bb, s2_bb;
  logic signed [CPW-1:0] d1, d2, d3, d4, den, num;
  logic signed [CPW-1:0] s2_d1, s2_d2, s2_d3, s2_d4, s2_den, s2_num;
  logic [QB:0] dv_v;
  dv_t dv [QB+1];
  dv_t dv0_next;

  assign en          = !dv_v[QB] || q_ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_ch.valid;
      s2_valid <= s1_valid;
    end
    if (en) begin
      s1 <= '{in_ch.a_start_x, in_ch.a_start_y, in_ch.a_end_x, in_ch.a_end_y,
             in_ch.b_start_x, in_ch.b_start_y, in_ch.b_end_x, in_ch.b_end_y};
      s2     <= s1;
      s2_bb  <= bb;
      s2_d1  <= d1;
      s2_d2  <= d2;
      s2_d3  <= d3;
      s2_d4  <= d4;
      s2_den <= den;
      s2_num <= num;
    end
  end

  always_comb begin
    logic signed [C-1:0] axmin, axmax, aymin, aymax, bxmin, bxmax, bymin, bymax;
    axmin = (s1.ax0 < s1.ax1) ? s1.ax0 : s1.ax1;
    axmax = (s1.ax0 > s1.ax1) ? s1.ax0 : s1.ax1;
    aymin = (s1.ay0 < s1.ay1) ? s1.ay0 : s1.ay1;
    aymax = (s1.ay0 > s1.ay1) ? s1.ay0 : s1.ay1;
    bxmin = (s1.bx0 < s1.bx1) ? s1.bx0 : s1.bx1;
    bxmax = (s1.bx0 > s1.bx1) ? s1.bx0 : s1.bx1;
    bymin = (s1.by0 < s1.by1) ? s1.by0 : s1.by1;
    bymax = (s1.by0 > s1.by1) ? s1.by0 : s1.by1;
    bb = !(axmax < bxmin || axmin > bxmax || aymax < bymin || aymin > bymax);
    d1 = crs(dif(s1.bx1, s1.bx0), dif(s1.by1, s1.by0),
             dif(s1.ax0, s1.bx0), dif(s1.ay0, s1.by0));
    d2 = crs(dif(s1.bx1, s1.bx0), dif(s1.by1, s1.by0),
             dif(s1.ax1, s1.bx0), dif(s1.ay1, s1.by0));
    d3 = crs(dif(s1.ax1, s1.ax0), dif(s1.ay1, s1.ay0),
             dif(s1.bx0, s1.ax0), dif(s1.by0, s1.ay0));
    d4 = crs(dif(s1.ax1, s1.ax0), dif(s1.ay1, s1.ay0),
             dif(s1.bx1, s1.ax0), dif(s1.by1, s1.ay0));
    den = crs(dif(s1.ax1, s1.ax0), dif(s1.ay1, s1.ay0),
              dif(s1.bx1, s1.bx0), dif(s1.by1, s1.by0));
    num = crs(dif(s1.bx0, s1.ax0), dif(s1.by0, s1.ay0),
              dif(s1.bx1, s1.bx0), dif(s1.by1, s1.by0));
  end

  always_comb begin
    logic hit, a_deg, b_deg;
    logic signed [DW-1:0] dxa, dya;
    logic [DENW-1:0] num_m;
    logic [MW-1:0] dxm, dym;
    logic [PRW-1:0] prx, pry;
    hit = s2_bb
        && !((s2_d1 > 0 && s2_d2 > 0) || (s2_d1 < 0 && s2_d2 < 0))
        && !((s2_d3 > 0 && s2_d4 > 0) || (s2_d3 < 0 && s2_d4 < 0));
    a_deg = (s2.ax0 == s2.ax1) && (s2.ay0 == s2.ay1);
    b_deg = (s2.bx0 == s2.bx1) && (s2.by0 == s2.by1);
    dxa   = dif(s2.ax1, s2.ax0);
    dya   = dif(s2.ay1, s2.ay0);
    num_m = DENW'((s2_num < 0) ? -s2_num : s2_num);
    dxm   = MW'((dxa < 0) ? -dxa : dxa);
    dym   = MW'((dya < 0) ? -dya : dya);
    prx   = num_m * dxm;
    pry   = num_m * dym;
    dv0_next              = '0;
    dv0_next.job.is_cross = hit && (s2_den != 0);
    if (hit && s2_den == 0) begin
      dv0_next.job.mask[0] = (s2.ax0 == s2.bx0 && s2.ay0 == s2.by0)
                          || (s2.ax0 == s2.bx1 && s2.ay0 == s2.by1);
      dv0_next.job.mask[1] = !a_deg && ((s2.ax1 == s2.bx0 && s2.ay1 == s2.by0)
                          || (s2.ax1 == s2.bx1 && s2.ay1 == s2.by1));
      dv0_next.job.mask[2] = inside_open(s2.ax0, s2.ay0, s2.bx0, s2.by0, s2.bx1, s2.by1);
      dv0_next.job.mask[3] = !a_deg
                          && inside_open(s2.ax1, s2.ay1, s2.bx0, s2.by0, s2.bx1, s2.by1);
      dv0_next.job.mask[4] = inside_open(s2.bx0, s2.by0, s2.ax0, s2.ay0, s2.ax1, s2.ay1);
      dv0_next.job.mask[5] = !b_deg
                          && inside_open(s2.bx1, s2.by1, s2.ax0, s2.ay0, s2.ax1, s2.ay1);
    end
    dv0_next.job.px[0] = to_pt(s2.ax0);
    dv0_next.job.py[0] = to_pt(s2.ay0);
    dv0_next.job.px[1] = to_pt(s2.ax1);
    dv0_next.job.py[1] = to_pt(s2.ay1);
    dv0_next.job.px[2] = to_pt(s2.bx0);
    dv0_next.job.py[2] = to_pt(s2.by0);
    dv0_next.job.px[3] = to_pt(s2.bx1);
    dv0_next.job.py[3] = to_pt(s2.by1);
    dv0_next.den = DENW'((s2_den < 0) ? -s2_den : s2_den);
    dv0_next.prx = prx;
    dv0_next.pry = pry;
    dv0_next.rx  = prx[PRW-1:MW];
    dv0_next.ry  = pry[PRW-1:MW];
    dv0_next.nx  = (s2_num < 0) ^ (s2_den < 0) ^ (dxa < 0);
    dv0_next.ny  = (s2_num < 0) ^ (s2_den < 0) ^ (dya < 0);
    dv0_next.bx  = s2.ax0;
    dv0_next.by  = s2.ay0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= s2_valid;
    end
    if (en) begin
      dv[0] <= dv0_next;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_div
    localparam int J = QB - i;
    localparam int K = (J >= F) ? J - F : 0;
    dv_t nxt;
    always_comb begin
      logic bx_in, by_in, gex, gey;
      logic [DENW:0] tx, ty;
      if (J >= F) begin
        bx_in = dv[i-1].prx[K];
        by_in = dv[i-1].pry[K];
      end else begin
        bx_in = 1'b0;
        by_in = 1'b0;
      end
      tx     = {dv[i-1].rx, bx_in};
      ty     = {dv[i-1].ry, by_in};
      gex    = tx >= {1'b0, dv[i-1].den};
      gey    = ty >= {1'b0, dv[i-1].den};
      nxt    = dv[i-1];
      nxt.rx = gex ? DENW'(tx - {1'b0, dv[i-1].den}) : DENW'(tx);
      nxt.ry = gey ? DENW'(ty - {1'b0, dv[i-1].den}) : DENW'(ty);
      nxt.qx = {dv[i-1].qx[QB-2:0], gex};
      nxt.qy = {dv[i-1].qy[QB-2:0], gey};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i] <= 1'b0;
      end else if (en) begin
        dv_v[i] <= dv_v[i-1];
      end
      if (en) begin
        dv[i] <= nxt;
      end
    end
  end

  always_comb begin
    q_push = dv_v[QB] && q_ready;
    q_data = dv[QB].job;
    if (dv[QB].job.is_cross) begin
      q_data.px[0] = fix(dv[QB].bx, dv[QB].qx, dv[QB].rx != '0, dv[QB].nx);
      q_data.py[0] = fix(dv[QB].by, dv[QB].qy, dv[QB].ry != '0, dv[QB].ny);
    end
  end

endmodule

// ===== hdl/segint_fifo.sv =====
// Short job queue between the front and the back.
module segint_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  segint_pkg::job_t push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output segint_pkg::job_t head
);

  localparam int PW = $clog2(segint_pkg::FIFO_DEPTH);

  segint_pkg::job_t mem [segint_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign not_full  = count != (PW+1)'(segint_pkg::FIFO_DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== hdl/segint_back.sv =====
// Back: expand each job into its result transactions through an output register.
module segint_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  segint_pkg::job_t q_head,
  output logic             q_pop,
  segint_out_if.source     out_ch
);

  logic                            act;
  segint_pkg::job_t                job;
  logic [segint_pkg::MASK_BITS-1:0] mask;
  logic                            o_valid, o_has, o_last;
  segint_pkg::pt_t                 o_x, o_y;
  logic                            adv, emit;
  logic                            has_next, last_next;
  segint_pkg::pt_t                 x_next, y_next;
  logic [segint_pkg::MASK_BITS-1:0] mask_next;

  assign adv   = !o_valid || out_ch.ready;
  assign emit  = act && adv;
  assign q_pop = !act && q_valid;

  assign out_ch.valid      = o_valid;
  assign out_ch.has_point  = o_has;
  assign out_ch.point_x    = o_x;
  assign out_ch.point_y    = o_y;
  assign out_ch.last_point = o_last;

  always_comb begin
    logic [2:0] idx;
    logic       found;
    idx       = '0;
    found     = 1'b0;
    for (int i = segint_pkg::MASK_BITS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx   = 3'(i);
        found = 1'b1;
      end
    end
    has_next  = 1'b1;
    x_next    = job.px[0];
    y_next    = job.py[0];
    mask_next = '0;
    last_next = 1'b1;
    if (!job.is_cross) begin
      if (!found) begin
        has_next = 1'b0;
        x_next   = '0;
        y_next   = '0;
      end else begin
        x_next    = job.px[segint_pkg::slot_of(idx)];
        y_next    = job.py[segint_pkg::slot_of(idx)];
        mask_next = mask & ~(segint_pkg::MASK_BITS'(1) << idx);
        last_next = mask_next == '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (q_pop) act <= 1'b1;
      else if (emit && last_next) act <= 1'b0;
      if (emit) o_valid <= 1'b1;
      else if (out_ch.ready) o_valid <= 1'b0;
    end
    if (q_pop) begin
      job  <= q_head;
      mask <= q_head.mask;
    end else if (emit) begin
      mask <= mask_next;
    end
    if (emit) begin
      o_has  <= has_next;
      o_x    <= x_next;
      o_y    <= y_next;
      o_last <= last_next;
    end
  end

endmodule

// ===== hdl/segment_intersection_points.sv =====
// Top level of the segment pair intersection block.
//
// in_ch carries one segment pair per transaction (valid/ready). out_ch
// carries result transactions: a pair that crosses gives one point, a
// collinear overlap gives up to six endpoint results, any other pair gives
// one result with has_point low. last_point marks the final result of a pair.
// Points are signed fixed point with FRAC_BITS fraction bits, 24 bits wide.
//
// The crossing point is formed by a bit-per-stage divider that follows the
// input registers. The front takes one pair per cycle unless a full queue
// stalls it; the back loads each pair from the queue and then emits its results
// one at a time, and takes no new pair until the last result has been emitted.
// A four-entry queue sits between front and back.
//
// Reset (rst, synchronous) empties the pipeline, the queue and the output
// register. When the receiver stalls, the output register holds, the queue
// fills and the front then drops in_ch.ready until room returns.
module segment_intersection_points #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  segint_in_if.sink     in_ch,
  segint_out_if.source  out_ch
);

  logic             q_ready, q_push, q_valid, q_pop;
  segint_pkg::job_t q_data, q_head;

  segint_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_ready(q_ready),
    .q_push (q_push),
    .q_data (q_data)
  );

  segint_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .not_full (q_ready),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  segint_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
